[rtl/mpdq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mpdq_pkg
// Shared types and constants of the microphone packet dedup queue.
// ----------------------------------------------------------------------------
package mpdq_pkg;

	// default sizing
	localparam int DEPTH_DEF         = 16;
	localparam int PAYLOAD_BYTES_DEF = 40;

	// register reset values
	localparam logic [31:0] MAX_AGE_RST    = 32'd40000;
	localparam logic [7:0]  DUP_WINDOW_RST = 8'd16;

	// configuration register indexes
	localparam logic CFG_MAX_AGE    = 1'b0;
	localparam logic CFG_DUP_WINDOW = 1'b1;

	// request commands
	typedef enum logic [1:0] {
		CMD_PUSH    = 2'd0,
		CMD_PULL    = 2'd1,
		CMD_SESSION = 2'd2,
		CMD_FLUSH   = 2'd3
	} cmd_t;

	// pull sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_EVAL,
		ST_SEND,
		ST_EMPTY
	} state_t;

	// slot header, written at payload word 0
	typedef struct packed {
		logic [31:0] frame;
		logic [7:0]  seq;
	} hdr_t;

	// slot stamp, written at commit
	typedef struct packed {
		logic [31:0] epoch;
		logic [31:0] stamp;
	} stamp_t;

	// everything the filter needs from one slot
	typedef struct packed {
		hdr_t   hdr;
		stamp_t st;
	} meta_t;

	// duplicate history
	typedef struct packed {
		logic [31:0] frame;
		logic [7:0]  seq;
		logic        valid;
	} hist_t;

	// filter decision for one entry
	typedef struct packed {
		logic drop;
		logic dup;
	} verdict_t;

	// sequencer control decode
	typedef struct packed {
		logic busy;
		logic meta_re;
		logic chk_en;
		logic eval;
		logic pay_re;
		logic emit_empty;
	} ctrl_t;

endpackage
`default_nettype wire

[rtl/mpdq_ring.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mpdq_ring
// Slot storage: header, stamp and payload memories with registered reads.
// ----------------------------------------------------------------------------
module mpdq_ring #(
	parameter int DEPTH  = mpdq_pkg::DEPTH_DEF,
	parameter int NWORDS = (mpdq_pkg::PAYLOAD_BYTES_DEF + 7) / 8
) (
	input  wire logic                                  clk,
	input  wire logic                                  hdr_we,
	input  wire logic                                  stamp_we,
	input  wire logic [$clog2(DEPTH)-1:0]              wr_slot,
	input  wire mpdq_pkg::hdr_t                        hdr_wdata,
	input  wire mpdq_pkg::stamp_t                      stamp_wdata,
	input  wire logic                                  pay_we,
	input  wire logic [$clog2(DEPTH*NWORDS)-1:0]       pay_waddr,
	input  wire logic [63:0]                           pay_wdata,
	input  wire logic                                  meta_re,
	input  wire logic [$clog2(DEPTH)-1:0]              rd_slot,
	output mpdq_pkg::meta_t                            meta_rdata,
	input  wire logic                                  pay_re,
	input  wire logic [$clog2(DEPTH*NWORDS)-1:0]       pay_raddr,
	output logic [63:0]                                pay_rdata
);

	mpdq_pkg::hdr_t   hdr_mem   [DEPTH];
	mpdq_pkg::stamp_t stamp_mem [DEPTH];
	logic [63:0]      pay_mem   [DEPTH*NWORDS];

	mpdq_pkg::hdr_t   hdr_rd_q;
	mpdq_pkg::stamp_t stamp_rd_q;

	// header memory
	always_ff @(posedge clk) begin
		if (hdr_we) begin
			hdr_mem[wr_slot] <= hdr_wdata;
		end
		if (meta_re) begin
			hdr_rd_q <= hdr_mem[rd_slot];
		end
	end

	// stamp memory
	always_ff @(posedge clk) begin
		if (stamp_we) begin
			stamp_mem[wr_slot] <= stamp_wdata;
		end
		if (meta_re) begin
			stamp_rd_q <= stamp_mem[rd_slot];
		end
	end

	// payload memory
	always_ff @(posedge clk) begin
		if (pay_we) begin
			pay_mem[pay_waddr] <= pay_wdata;
		end
		if (pay_re) begin
			pay_rdata <= pay_mem[pay_raddr];
		end
	end

	assign meta_rdata.hdr = hdr_rd_q;
	assign meta_rdata.st  = stamp_rd_q;

endmodule
`default_nettype wire

[rtl/mpdq_filter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mpdq_filter
// Shared compare unit: judges one ring entry per use as stale, duplicate or good.
// ----------------------------------------------------------------------------
module mpdq_filter (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire mpdq_pkg::meta_t   meta,
	input  wire mpdq_pkg::hist_t   hist,
	input  wire logic [31:0]       session_epoch,
	input  wire logic [31:0]       now,
	input  wire logic [31:0]       max_age,
	input  wire logic [7:0]        dup_window,
	output mpdq_pkg::verdict_t     verdict_q
);

	logic [31:0] age;
	logic [31:0] delta;
	logic        stale;
	logic        dup;

	// age and frame distance, both modulo 2^32
	always_comb begin
		age   = now - meta.st.stamp;
		delta = meta.hdr.frame - hist.frame;
		stale = (meta.st.epoch != session_epoch) || (age > max_age);
		dup   = hist.valid && ((delta == 32'd0) ||
			((meta.hdr.seq == hist.seq) && (delta < {24'd0, dup_window})));
	end

	// registered verdict, stale wins over duplicate
	always_ff @(posedge clk) begin
		if (en) begin
			verdict_q.drop <= stale;
			verdict_q.dup  <= !stale && dup;
		end
	end

endmodule
`default_nettype wire

[rtl/mic_packet_dedup_queue_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mic_packet_dedup_queue_unit
// Packet ring with stale-entry and duplicate filtering on dequeue.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Push, new session
// and flush requests finish in the accepting cycle and leave busy low.
// A pull walks the ring: each entry examined goes through a slot memory
// read, a filter compare and a decision. A good entry then streams NWORDS result
// items, one per cycle, through the send state, the payload memory read and the
// result register after the decision; an empty pull gives one result item
// through the empty state and the result register after the last decision or
// after accept. busy drops in the cycle before the last word of a packet is out.
// Results appear for one cycle with out_valid high and cannot be stalled.
// Configuration writes (cfg_write, cfg_index, cfg_data) land at once and are
// meant for idle periods only.
// Reset empties the ring, clears history, counters and epoch and restores
// max_age_us = 40000 and dup_window = 16. Slot memories are not cleared.
// ----------------------------------------------------------------------------
module mic_packet_dedup_queue_unit #(
	parameter int DEPTH         = mpdq_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BYTES = mpdq_pkg::PAYLOAD_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  command,
	input  wire logic [31:0] frame_number,
	input  wire logic [7:0]  seq_byte,
	input  wire logic [63:0] payload_word,
	input  wire logic [2:0]  word_index,
	input  wire logic [31:0] now_us,
	input  wire logic        active,
	input  wire logic        capture,
	// configuration port
	input  wire logic        cfg_write,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data,
	// result channel
	output logic             out_valid,
	output logic             found,
	output logic [31:0]      out_frame,
	output logic [63:0]      out_word,
	output logic [2:0]       out_index,
	output logic             last,
	output logic [31:0]      dropped_total,
	output logic [31:0]      duplicate_total
);

	localparam int NWORDS = (PAYLOAD_BYTES + 7) / 8;
	localparam int PW     = $clog2(2 * DEPTH);
	localparam int SW     = $clog2(DEPTH);
	localparam int PAW    = $clog2(DEPTH * NWORDS);

	localparam logic [PW:0]   DEPTH_X  = (PW + 1)'(DEPTH);
	localparam logic [PW:0]   MOD_X    = (PW + 1)'(2 * DEPTH);
	localparam logic [PW-1:0] PTR_TOP  = PW'(2 * DEPTH - 1);
	localparam logic [2:0]    LAST_IDX = 3'(NWORDS - 1);
	localparam logic [3:0]    NWORDS_X = 4'(NWORDS);

	mpdq_pkg::state_t state_q, state_nxt;
	mpdq_pkg::ctrl_t  ctrl;

	logic [PW-1:0] wp_q, rp_q, wp_inc, rp_inc;
	logic [PW:0]   wp_x, rp_x, occ;
	logic          full;
	logic [SW-1:0] wr_slot, rd_slot, cur_slot_q;

	logic [31:0]   epoch_q;
	logic [31:0]   max_age_q;
	logic [7:0]    dup_window_q;
	logic [31:0]   now_q;
	logic [31:0]   drop_count_q;
	logic [31:0]   dup_count_q;
	logic          rejected_q;
	mpdq_pkg::hist_t hist_q;

	logic [2:0]    k_q;
	logic          emit_s1;
	logic [2:0]    k_s1;

	logic          accept;
	logic          is_push;
	logic          in_range;
	logic          push_go;
	logic          push_full0;
	logic          commit;
	logic          commit_ok;
	logic          commit_drop;
	logic          hdr_we;

	logic [PAW-1:0] pay_waddr;
	logic [PAW-1:0] pay_raddr;

	mpdq_pkg::hdr_t     hdr_wdata;
	mpdq_pkg::stamp_t   stamp_wdata;
	mpdq_pkg::meta_t    meta_rdata;
	mpdq_pkg::verdict_t verdict;
	logic [63:0]        pay_rdata;
	logic               skip;

	// pointer arithmetic, pointers count modulo 2*DEPTH
	always_comb begin
		wp_x    = {1'b0, wp_q};
		rp_x    = {1'b0, rp_q};
		occ     = (wp_q >= rp_q) ? (wp_x - rp_x) : (wp_x + MOD_X - rp_x);
		full    = (occ == DEPTH_X);
		wr_slot = (wp_x >= DEPTH_X) ? SW'(wp_x - DEPTH_X) : SW'(wp_x);
		rd_slot = (rp_x >= DEPTH_X) ? SW'(rp_x - DEPTH_X) : SW'(rp_x);
		wp_inc  = (wp_q == PTR_TOP) ? '0 : wp_q + PW'(1);
		rp_inc  = (rp_q == PTR_TOP) ? '0 : rp_q + PW'(1);
	end

	// push decode
	always_comb begin
		accept      = start && !busy;
		is_push     = accept && (mpdq_pkg::cmd_t'(command) == mpdq_pkg::CMD_PUSH);
		in_range    = ({1'b0, word_index} < NWORDS_X);
		push_full0  = is_push && active && in_range && (word_index == 3'd0) && full;
		push_go     = is_push && active && in_range &&
			((word_index == 3'd0) ? !full : !rejected_q);
		hdr_we      = push_go && (word_index == 3'd0);
		commit      = push_go && (word_index == LAST_IDX);
		commit_ok   = commit && !full;
		commit_drop = commit && full;
		pay_waddr   = PAW'(PAW'(wr_slot) * PAW'(NWORDS)) + PAW'(word_index);
		pay_raddr   = PAW'(PAW'(cur_slot_q) * PAW'(NWORDS)) + PAW'(k_q);
		hdr_wdata   = '{frame: frame_number, seq: seq_byte};
		stamp_wdata = '{epoch: epoch_q, stamp: now_us};
		skip        = verdict.drop || verdict.dup;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mpdq_pkg::ST_IDLE: begin
				if (accept && (mpdq_pkg::cmd_t'(command) == mpdq_pkg::CMD_PULL)) begin
					if (!capture || (rp_q == wp_q)) begin
						state_nxt = mpdq_pkg::ST_EMPTY;
					end else begin
						state_nxt = mpdq_pkg::ST_READ;
					end
				end
			end
			mpdq_pkg::ST_READ:  state_nxt = mpdq_pkg::ST_CHECK;
			mpdq_pkg::ST_CHECK: state_nxt = mpdq_pkg::ST_EVAL;
			mpdq_pkg::ST_EVAL: begin
				if (!skip) begin
					state_nxt = mpdq_pkg::ST_SEND;
				end else if (rp_inc == wp_q) begin
					state_nxt = mpdq_pkg::ST_EMPTY;
				end else begin
					state_nxt = mpdq_pkg::ST_READ;
				end
			end
			mpdq_pkg::ST_SEND: begin
				if (k_q == LAST_IDX) begin
					state_nxt = mpdq_pkg::ST_IDLE;
				end
			end
			mpdq_pkg::ST_EMPTY: state_nxt = mpdq_pkg::ST_IDLE;
			default:            state_nxt = mpdq_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctrl            = '0;
		ctrl.busy       = (state_q != mpdq_pkg::ST_IDLE);
		ctrl.meta_re    = (state_q == mpdq_pkg::ST_READ);
		ctrl.chk_en     = (state_q == mpdq_pkg::ST_CHECK);
		ctrl.eval       = (state_q == mpdq_pkg::ST_EVAL);
		ctrl.pay_re     = (state_q == mpdq_pkg::ST_SEND);
		ctrl.emit_empty = (state_q == mpdq_pkg::ST_EMPTY);
	end

	assign busy = ctrl.busy;

	// slot storage
	mpdq_ring #(
		.DEPTH  (DEPTH),
		.NWORDS (NWORDS)
	) u_ring (
		.clk         (clk),
		.hdr_we      (hdr_we),
		.stamp_we    (commit_ok),
		.wr_slot     (wr_slot),
		.hdr_wdata   (hdr_wdata),
		.stamp_wdata (stamp_wdata),
		.pay_we      (push_go),
		.pay_waddr   (pay_waddr),
		.pay_wdata   (payload_word),
		.meta_re     (ctrl.meta_re),
		.rd_slot     (rd_slot),
		.meta_rdata  (meta_rdata),
		.pay_re      (ctrl.pay_re),
		.pay_raddr   (pay_raddr),
		.pay_rdata   (pay_rdata)
	);

	// entry filter
	mpdq_filter u_filter (
		.clk           (clk),
		.en            (ctrl.chk_en),
		.meta          (meta_rdata),
		.hist          (hist_q),
		.session_epoch (epoch_q),
		.now           (now_q),
		.max_age       (max_age_q),
		.dup_window    (dup_window_q),
		.verdict_q     (verdict)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpdq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q    <= mpdq_pkg::MAX_AGE_RST;
			dup_window_q <= mpdq_pkg::DUP_WINDOW_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				mpdq_pkg::CFG_MAX_AGE:    max_age_q    <= cfg_data;
				mpdq_pkg::CFG_DUP_WINDOW: dup_window_q <= cfg_data[7:0];
				default:                  max_age_q    <= max_age_q;
			endcase
		end
	end

	// ring pointers, epoch, push state, history and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q         <= '0;
			rp_q         <= '0;
			epoch_q      <= '0;
			rejected_q   <= 1'b0;
			hist_q       <= '0;
			drop_count_q <= '0;
			dup_count_q  <= '0;
		end else begin
			if (commit_ok) begin
				wp_q <= wp_inc;
			end

			// push abort and re-arm
			if (is_push && !active) begin
				rejected_q <= 1'b1;
			end else if (push_full0 || commit) begin
				rejected_q <= 1'b1;
			end else if (hdr_we) begin
				rejected_q <= 1'b0;
			end else if (accept &&
				(mpdq_pkg::cmd_t'(command) == mpdq_pkg::CMD_FLUSH)) begin
				rejected_q <= 1'b1;
			end

			// session epoch
			if (accept && (mpdq_pkg::cmd_t'(command) == mpdq_pkg::CMD_SESSION)) begin
				epoch_q <= epoch_q + 32'd1;
			end

			// discard ring: flush or pull with capture off
			if (accept && ((mpdq_pkg::cmd_t'(command) == mpdq_pkg::CMD_FLUSH) ||
				((mpdq_pkg::cmd_t'(command) == mpdq_pkg::CMD_PULL) && !capture))) begin
				rp_q         <= wp_q;
				hist_q.valid <= 1'b0;
			end else if (ctrl.eval) begin
				rp_q <= rp_inc;
				if (!skip) begin
					hist_q.frame <= meta_rdata.hdr.frame;
					hist_q.seq   <= meta_rdata.hdr.seq;
					hist_q.valid <= 1'b1;
				end
			end

			// counters
			if (push_full0 || commit_drop || (ctrl.eval && verdict.drop)) begin
				drop_count_q <= drop_count_q + 32'd1;
			end
			if (ctrl.eval && verdict.dup) begin
				dup_count_q <= dup_count_q + 32'd1;
			end
		end
	end

	// pull context
	always_ff @(posedge clk) begin
		if (accept) begin
			now_q <= now_us;
		end
		if (ctrl.meta_re) begin
			cur_slot_q <= rd_slot;
		end
	end

	// payload word counter and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			emit_s1 <= 1'b0;
			k_s1    <= '0;
		end else begin
			k_q     <= ctrl.pay_re ? k_q + 3'd1 : 3'd0;
			emit_s1 <= ctrl.pay_re;
			k_s1    <= k_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= ctrl.emit_empty || emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit_empty) begin
			found           <= 1'b0;
			out_frame       <= '0;
			out_word        <= '0;
			out_index       <= '0;
			last            <= 1'b1;
			dropped_total   <= drop_count_q;
			duplicate_total <= dup_count_q;
		end else if (emit_s1) begin
			found           <= 1'b1;
			out_frame       <= hist_q.frame;
			out_word        <= pay_rdata;
			out_index       <= k_s1;
			last            <= (k_s1 == LAST_IDX);
			dropped_total   <= drop_count_q;
			duplicate_total <= dup_count_q;
		end
	end

	// checks
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= DEPTH_X)
		else $error("ring occupancy above depth");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |=> !(out_valid && found))
		else $error("packet word right after final result of a pull");

	a_empty_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> last && (out_index == 3'd0))
		else $error("empty pull result malformed");

	a_send_hist: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mpdq_pkg::ST_SEND) |-> hist_q.valid)
		else $error("sending without updated history");

	a_pull_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (command == mpdq_pkg::CMD_PULL) |=> busy)
		else $error("pull request did not start the sequencer");

endmodule
`default_nettype wire

[tb/tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the microphone packet dedup queue. A driver feeds
// requests from a queue with random gaps, a predictor of the ring and its
// stale and duplicate filter computes the results of each accepted request,
// and a monitor compares every result item field by field.
// ----------------------------------------------------------------------------
module tb;

	localparam int DEPTH  = mpdq_pkg::DEPTH_DEF;
	localparam int NWORDS = (mpdq_pkg::PAYLOAD_BYTES_DEF + 7) / 8;
	localparam int SLOT_W = $clog2(DEPTH);
	localparam int PTR_W  = SLOT_W + 1;

	// one request as it goes onto the ports
	typedef struct packed {
		mpdq_pkg::cmd_t cmd;
		logic [31:0] frame;
		logic [7:0]  seq;
		logic [63:0] word;
		logic [2:0]  idx;
		logic [31:0] now;
		logic        active;
		logic        capture;
	} req_t;

	// one result item
	typedef struct packed {
		logic        found;
		logic [31:0] frame;
		logic [63:0] word;
		logic [2:0]  idx;
		logic        fin;
		logic [31:0] drops;
		logic [31:0] dups;
	} res_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// request channel
	logic start    = 1'b0;
	req_t drv_req  = '0;
	logic busy;

	// configuration port
	logic        cfg_write = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data  = '0;

	// result channel
	logic        out_valid;
	logic        found;
	logic [31:0] out_frame;
	logic [63:0] out_word;
	logic [2:0]  out_index;
	logic        last;
	logic [31:0] dropped_total;
	logic [31:0] duplicate_total;

	req_t        request_q[$];
	res_t        due_results[$];
	int unsigned mismatch_cnt = 0;
	int unsigned calm_left    = 0;
	int unsigned pause_left   = 0;
	logic [31:0] mic_clock    = '0;

	// predicted ring state
	logic [PTR_W-1:0] wr_ptr     = '0;
	logic [PTR_W-1:0] rd_ptr     = '0;
	logic [31:0]      sess_epoch = '0;
	logic [31:0]      ring_frame [DEPTH];
	logic [7:0]       ring_seq   [DEPTH];
	logic [31:0]      ring_epoch [DEPTH];
	logic [31:0]      ring_stamp [DEPTH];
	logic [63:0]      ring_word  [DEPTH][NWORDS];
	logic [31:0]      hist_frame = '0;
	logic [7:0]       hist_seq   = '0;
	logic             hist_valid = 1'b0;
	logic             hdr_closed = 1'b0;
	logic [31:0]      drop_cnt   = '0;
	logic [31:0]      dup_cnt    = '0;
	logic [31:0]      age_limit  = mpdq_pkg::MAX_AGE_RST;
	logic [7:0]       dup_win    = mpdq_pkg::DUP_WINDOW_RST;

	mic_packet_dedup_queue_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (drv_req.cmd),
		.frame_number    (drv_req.frame),
		.seq_byte        (drv_req.seq),
		.payload_word    (drv_req.word),
		.word_index      (drv_req.idx),
		.now_us          (drv_req.now),
		.active          (drv_req.active),
		.capture         (drv_req.capture),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.found           (found),
		.out_frame       (out_frame),
		.out_word        (out_word),
		.out_index       (out_index),
		.last            (last),
		.dropped_total   (dropped_total),
		.duplicate_total (duplicate_total)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// update the predicted ring for one accepted request, queue its results
	task automatic advance_ring(input req_t r);
		logic [SLOT_W-1:0] s;
		logic [PTR_W-1:0]  fill;
		logic [31:0]       gap;
		logic              take;
		logic              sent;
		s    = wr_ptr[SLOT_W-1:0];
		fill = wr_ptr - rd_ptr;
		sent = 1'b0;
		case (r.cmd)
			mpdq_pkg::CMD_PUSH: begin
				if (!r.active) begin
					hdr_closed = 1'b1;
				end else if (r.idx < NWORDS) begin
					take = 1'b1;
					if (r.idx == 0) begin
						if (fill >= DEPTH) begin
							drop_cnt++;
							hdr_closed = 1'b1;
							take = 1'b0;
						end else begin
							hdr_closed = 1'b0;
							ring_frame[s] = r.frame;
							ring_seq[s] = r.seq;
						end
					end else if (hdr_closed) begin
						take = 1'b0;
					end
					if (take) begin
						ring_word[s][r.idx] = r.word;
						// last word commits the slot
						if (r.idx == NWORDS - 1) begin
							hdr_closed = 1'b1;
							if (fill >= DEPTH) begin
								drop_cnt++;
							end else begin
								ring_epoch[s] = sess_epoch;
								ring_stamp[s] = r.now;
								wr_ptr++;
							end
						end
					end
				end
			end
			mpdq_pkg::CMD_PULL: begin
				if (!r.capture) begin
					rd_ptr = wr_ptr;
					hist_valid = 1'b0;
				end else begin
					// drain until a good entry turns up
					while (!sent && rd_ptr != wr_ptr) begin
						s = rd_ptr[SLOT_W-1:0];
						rd_ptr++;
						gap = ring_frame[s] - hist_frame;
						if (ring_epoch[s] != sess_epoch ||
								(r.now - ring_stamp[s]) > age_limit) begin
							drop_cnt++;
						end else if (hist_valid && (gap == 0 ||
								(ring_seq[s] == hist_seq && gap < dup_win))) begin
							dup_cnt++;
						end else begin
							hist_frame = ring_frame[s];
							hist_seq = ring_seq[s];
							hist_valid = 1'b1;
							sent = 1'b1;
							for (int k = 0; k < NWORDS; k++)
								due_results.push_back('{1'b1, ring_frame[s], ring_word[s][k],
									3'(k), k == NWORDS - 1, drop_cnt, dup_cnt});
						end
					end
				end
				if (!sent)
					due_results.push_back('{1'b0, 32'd0, 64'd0, 3'd0, 1'b1, drop_cnt, dup_cnt});
			end
			mpdq_pkg::CMD_SESSION: begin
				sess_epoch++;
			end
			default: begin
				rd_ptr = wr_ptr;
				hist_valid = 1'b0;
				hdr_closed = 1'b1;
			end
		endcase
	endtask

	// request driver with random gaps and gap-free stretches
	always @(posedge clk or negedge arst_n) begin : drv
		logic        took;
		int unsigned pause;
		int unsigned roll;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			took = start && !busy;
			pause = 0;
			if (took) begin
				advance_ring(drv_req);
				if (calm_left != 0) begin
					calm_left--;
				end else begin
					roll = $urandom_range(0, 99);
					if (roll < 4)
						calm_left = $urandom_range(10, 40);
					else if (roll >= 90)
						pause = $urandom_range(4, 40);
					else if (roll >= 50)
						pause = $urandom_range(1, 3);
				end
			end else if (!start && calm_left == 0) begin
				pause = pause_left;
			end
			if (start && !took) begin
				// request still waiting for busy to drop
			end else if (pause != 0) begin
				start <= 1'b0;
				pause_left <= pause - 1;
			end else if (request_q.size() != 0) begin
				drv_req <= request_q.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic flag_mismatch(input string what);
		mismatch_cnt++;
		$display("%0t: mismatch, %s", $time, what);
	endtask

	function automatic string show(input res_t v);
		return $sformatf("found=%0b frame=%h word=%h idx=%0d last=%0b drops=%0d dups=%0d",
			v.found, v.frame, v.word, v.idx, v.fin, v.drops, v.dups);
	endfunction

	// result monitor
	always @(posedge clk) begin : mon
		res_t seen;
		res_t want;
		if (arst_n && out_valid) begin
			seen = {found, out_frame, out_word, out_index, last, dropped_total, duplicate_total};
			if (due_results.size() == 0) begin
				flag_mismatch({"unexpected result ", show(seen)});
			end else begin
				want = due_results.pop_front();
				if (seen !== want)
					flag_mismatch({"got ", show(seen), " want ", show(want)});
			end
		end
	end

	function automatic req_t blank_req(input mpdq_pkg::cmd_t c);
		req_t r;
		r.cmd = c;
		r.frame = $urandom;
		r.seq = 8'($urandom);
		r.word = {$urandom, $urandom};
		r.idx = 3'($urandom);
		r.now = mic_clock;
		r.active = 1'b1;
		r.capture = 1'b1;
		return r;
	endfunction

	// one well-formed packet, words 0 to NWORDS-1
	task automatic queue_packet(input logic [31:0] frame, input logic [7:0] seq,
			input logic [63:0] fill_word, input logic fixed);
		req_t r;
		for (int k = 0; k < NWORDS; k++) begin
			r = blank_req(mpdq_pkg::CMD_PUSH);
			r.idx = 3'(k);
			if (k == 0) begin
				r.frame = frame;
				r.seq = seq;
			end
			if (fixed)
				r.word = fill_word;
			request_q.push_back(r);
		end
	endtask

	// wait until the block is idle with nothing outstanding
	task automatic settle();
		do
			@(posedge clk);
		while (request_q.size() != 0 || start || due_results.size() != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] age, input logic [31:0] dup_data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= mpdq_pkg::CFG_MAX_AGE;
		cfg_data <= age;
		@(posedge clk);
		cfg_index <= mpdq_pkg::CFG_DUP_WINDOW;
		cfg_data <= dup_data;
		@(posedge clk);
		cfg_write <= 1'b0;
		age_limit = age;
		dup_win = dup_data[7:0];
	endtask

	task automatic random_phase(input int unsigned quota, input int unsigned pull_pct);
		int unsigned done;
		int unsigned roll;
		int unsigned n;
		logic [31:0] frame_ctr;
		logic [7:0]  pkt_seq;
		req_t        r;
		done = 0;
		frame_ctr = $urandom;
		pkt_seq = frame_ctr[7:0];
		while (done < quota) begin
			roll = $urandom_range(0, 99);
			if (roll < pull_pct) begin
				r = blank_req(mpdq_pkg::CMD_PULL);
				r.capture = ($urandom_range(0, 14) != 0);
				request_q.push_back(r);
				done++;
			end else if (roll < pull_pct + 3) begin
				request_q.push_back(blank_req(mpdq_pkg::CMD_SESSION));
				done++;
			end else if (roll < pull_pct + 6) begin
				request_q.push_back(blank_req(mpdq_pkg::CMD_FLUSH));
				done++;
			end else if (roll < pull_pct + 13) begin
				// broken packet: stray words, aborts and bad indexes
				n = $urandom_range(1, 6);
				repeat (n) begin
					r = blank_req(mpdq_pkg::CMD_PUSH);
					r.active = ($urandom_range(0, 3) != 0);
					request_q.push_back(r);
				end
			end else begin
				// good packet, sometimes repeating the frame or the sequence byte
				roll = $urandom_range(0, 9);
				if (roll == 1) begin
					frame_ctr += $urandom_range(1, 40);
				end else if (roll > 1) begin
					frame_ctr += 1;
					pkt_seq = frame_ctr[7:0];
				end
				queue_packet(frame_ctr, pkt_seq, '0, 1'b0);
				done += NWORDS;
			end
			// capture time runs on, with rare long jumps and steps back
			roll = $urandom_range(0, 99);
			if (roll >= 99)
				mic_clock -= $urandom_range(1, 500);
			else if (roll >= 95)
				mic_clock += $urandom_range(30000, 90000);
			else if (roll >= 30)
				mic_clock += $urandom_range(1, 3000);
		end
	endtask

	// stimulus sequence
	initial begin : stim
		int unsigned i;
		req_t        r;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		mic_clock = $urandom;

		// pull on an empty ring
		request_q.push_back(blank_req(mpdq_pkg::CMD_PULL));
		// fill every slot; frames cross the 32-bit wrap, payload extremes first
		for (i = 0; i < DEPTH; i++)
			queue_packet(32'hFFFF_FFF8 + i, (i == DEPTH - 1) ? 8'hFF : i[7:0],
				(i == 1) ? '1 : '0, i < 2);
		// ring full: dropped at word 0, the rest of its words ignored
		queue_packet(32'h1234_5678, 8'hAA, '0, 1'b0);
		request_q.push_back(blank_req(mpdq_pkg::CMD_PULL));
		// new session: what is left belongs to the old epoch
		request_q.push_back(blank_req(mpdq_pkg::CMD_SESSION));
		request_q.push_back(blank_req(mpdq_pkg::CMD_PULL));
		// repeated frame, repeated sequence byte inside and outside the window
		queue_packet(32'd100, 8'd7, '0, 1'b0);
		queue_packet(32'd100, 8'd9, '0, 1'b0);
		queue_packet(32'd110, 8'd7, '0, 1'b0);
		queue_packet(32'd140, 8'd7, '0, 1'b0);
		repeat (3) request_q.push_back(blank_req(mpdq_pkg::CMD_PULL));
		// inactive word 1 aborts the packet, indexes past the payload ignored
		for (i = 0; i < 8; i++) begin
			r = blank_req(mpdq_pkg::CMD_PUSH);
			r.idx = 3'(i);
			r.frame = 32'd200;
			r.active = (i != 1);
			request_q.push_back(r);
		end
		request_q.push_back(blank_req(mpdq_pkg::CMD_PULL));
		// one entry just past the age limit, the next exactly at it
		queue_packet(32'd300, 8'd1, '0, 1'b0);
		mic_clock += 1;
		queue_packet(32'd301, 8'd2, '0, 1'b0);
		mic_clock += mpdq_pkg::MAX_AGE_RST;
		request_q.push_back(blank_req(mpdq_pkg::CMD_PULL));
		// pull with capture off discards the ring
		queue_packet(32'd400, 8'd3, '0, 1'b0);
		r = blank_req(mpdq_pkg::CMD_PULL);
		r.capture = 1'b0;
		request_q.push_back(r);
		request_q.push_back(blank_req(mpdq_pkg::CMD_PULL));
		// flush
		queue_packet(32'd500, 8'd4, '0, 1'b0);
		request_q.push_back(blank_req(mpdq_pkg::CMD_FLUSH));
		request_q.push_back(blank_req(mpdq_pkg::CMD_PULL));
		settle();

		set_config(32'hFFFF_FFFF, ($urandom & 32'hFFFF_FF00) | 32'd255);
		random_phase(70, 15);
		settle();
		set_config(32'd0, $urandom & 32'hFFFF_FF00);
		random_phase(70, 30);
		settle();
		set_config(mpdq_pkg::MAX_AGE_RST,
			($urandom & 32'hFFFF_FF00) | mpdq_pkg::DUP_WINDOW_RST);
		random_phase(70, 20);
		settle();
		set_config($urandom_range(1000, 100000), $urandom_range(1, 254));
		random_phase(70, 25);
		settle();
		set_config($urandom, $urandom);
		random_phase(70, 35);
		settle();

		if (mismatch_cnt == 0 && due_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// run limit
	initial begin : watchdog
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire
